[hw/rtl/vawj_pkg.sv]
package vawj_pkg;

  // fixed-point angle constants
  localparam logic [17:0] PI_Q16      = 18'd205887;
  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;

  // pipeline geometry
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;
  localparam int FRONT_LAT    = 6;
  localparam int SETUP_LAT    = 2;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int DIV_LAT      = DIV_STEPS + 1;
  localparam int TOTAL_LAT    = FRONT_LAT + SQRT_STEPS + SETUP_LAT + DIV_LAT + 1;
  localparam int NUM_LANES    = 6;

  // configuration register indexes
  localparam logic [1:0] CFG_EN_FIRST  = 2'd0;
  localparam logic [1:0] CFG_EN_SECOND = 2'd1;

  typedef struct packed {
    logic valid;
    logic degen;
    logic negdot;
  } flags_t;

  // everything that rides alongside the square root
  typedef struct packed {
    flags_t          fl;
    logic [31:0]     adot;
    logic [4:0]      adot_msb;
    logic            adot_nz;
    logic [4:0]      s;
    logic [31:0]     ll;
    logic [31:0]     rr;
    logic [5:0][48:0] mag;
    logic [5:0]      neg;
  } side_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:    a = 30'd843314857;
      5'd1:    a = 30'd497837829;
      5'd2:    a = 30'd263043837;
      5'd3:    a = 30'd133525159;
      5'd4:    a = 30'd67021687;
      5'd5:    a = 30'd33543516;
      5'd6:    a = 30'd16775851;
      5'd7:    a = 30'd8388437;
      5'd8:    a = 30'd4194283;
      5'd9:    a = 30'd2097149;
      default: a = 30'd1 << (5'd30 - i);
    endcase
    return a;
  endfunction

endpackage

[hw/rtl/vawj_front.sv]
module vawj_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [15:0]    first_x,
  input  logic signed [15:0]    first_y,
  input  logic signed [15:0]    first_z,
  input  logic signed [15:0]    second_x,
  input  logic signed [15:0]    second_y,
  input  logic signed [15:0]    second_z,
  output vawj_pkg::side_t       side,
  output logic [63:0]           norm_c2
);

  // stage 1: all 16x16 products
  logic               v1;
  logic signed [15:0] l1 [3];
  logic signed [15:0] r1 [3];
  logic signed [31:0] pc1 [6];
  logic signed [31:0] pd1 [3];
  logic signed [31:0] pl1 [3];
  logic signed [31:0] pr1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    l1[0] <= first_x;  l1[1] <= first_y;  l1[2] <= first_z;
    r1[0] <= second_x; r1[1] <= second_y; r1[2] <= second_z;
    pc1[0] <= first_y * second_z;  pc1[1] <= first_z * second_y;
    pc1[2] <= first_z * second_x;  pc1[3] <= first_x * second_z;
    pc1[4] <= first_x * second_y;  pc1[5] <= first_y * second_x;
    pd1[0] <= first_x * second_x;  pd1[1] <= first_y * second_y;
    pd1[2] <= first_z * second_z;
    pl1[0] <= first_x * first_x;   pl1[1] <= first_y * first_y;
    pl1[2] <= first_z * first_z;
    pr1[0] <= second_x * second_x; pr1[1] <= second_y * second_y;
    pr1[2] <= second_z * second_z;
  end

  // stage 2: cross, dot and squared lengths
  logic               v2;
  logic signed [15:0] l2 [3];
  logic signed [15:0] r2 [3];
  logic signed [32:0] cr2 [3];
  logic signed [32:0] dot2;
  logic [31:0]        ll2, rr2;
  logic signed [32:0] cr_w [3];
  logic signed [32:0] dot_w;

  always_comb begin
    cr_w[0] = pc1[0] - pc1[1];
    cr_w[1] = pc1[2] - pc1[3];
    cr_w[2] = pc1[4] - pc1[5];
    dot_w   = pd1[0] + pd1[1] + pd1[2];
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    l2   <= l1;
    r2   <= r1;
    cr2  <= cr_w;
    dot2 <= dot_w;
    ll2  <= $unsigned(pl1[0]) + $unsigned(pl1[1]) + $unsigned(pl1[2]);
    rr2  <= $unsigned(pr1[0]) + $unsigned(pr1[1]) + $unsigned(pr1[2]);
  end

  // stage 3: squares of the cross product, numerator products
  logic               v3, degen3, negdot3;
  logic [63:0]        csq3 [3];
  logic signed [48:0] dl3 [3];
  logic signed [48:0] lr3 [3];
  logic signed [48:0] dr3 [3];
  logic signed [48:0] rl3 [3];
  logic [31:0]        adot3, ll3, rr3;
  logic signed [65:0] csq_w [3];
  logic signed [48:0] dl_w [3];
  logic signed [48:0] lr_w [3];
  logic signed [48:0] dr_w [3];
  logic signed [48:0] rl_w [3];
  logic signed [32:0] ndot_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csq_w[k] = cr2[k] * cr2[k];
      dl_w[k]  = dot2 * l2[k];
      lr_w[k]  = $signed({1'b0, ll2}) * r2[k];
      dr_w[k]  = dot2 * r2[k];
      rl_w[k]  = $signed({1'b0, rr2}) * l2[k];
    end
    ndot_w = -dot2;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int k = 0; k < 3; k++) begin
      csq3[k] <= csq_w[k][63:0];
      dl3[k]  <= dl_w[k];
      lr3[k]  <= lr_w[k];
      dr3[k]  <= dr_w[k];
      rl3[k]  <= rl_w[k];
    end
    degen3  <= (cr2[0] == '0) && (cr2[1] == '0) && (cr2[2] == '0);
    negdot3 <= dot2[32];
    adot3   <= dot2[32] ? ndot_w[31:0] : dot2[31:0];
    ll3     <= ll2;
    rr3     <= rr2;
  end

  // stage 4: sum of squares, numerators, leading one of |dot|
  vawj_pkg::side_t    sd4;
  logic [63:0]        c2_4;
  logic signed [49:0] num4 [6];
  logic signed [49:0] num_w [6];
  logic [31:0]        msb_v;
  logic [4:0]         msb_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_w[k]     = dl3[k] - lr3[k];
      num_w[k + 3] = dr3[k] - rl3[k];
    end
    msb_v = adot3;
    msb_w = '0;
    if (msb_v[31:16] != '0) begin msb_w[4] = 1'b1; msb_v = msb_v >> 16; end
    if (msb_v[15:8]  != '0) begin msb_w[3] = 1'b1; msb_v = msb_v >> 8;  end
    if (msb_v[7:4]   != '0) begin msb_w[2] = 1'b1; msb_v = msb_v >> 4;  end
    if (msb_v[3:2]   != '0) begin msb_w[1] = 1'b1; msb_v = msb_v >> 2;  end
    if (msb_v[1])           msb_w[0] = 1'b1;
  end

  always_ff @(posedge clk) begin
    c2_4 <= csq3[0] + csq3[1] + csq3[2];
    num4 <= num_w;
    sd4.fl.degen  <= degen3;
    sd4.fl.negdot <= negdot3;
    sd4.adot      <= adot3;
    sd4.adot_msb  <= msb_w;
    sd4.adot_nz   <= (adot3 != '0);
    sd4.s         <= '0;
    sd4.ll        <= ll3;
    sd4.rr        <= rr3;
    sd4.mag       <= '0;
    sd4.neg       <= '0;
    if (rst) sd4.fl.valid <= 1'b0;
    else     sd4.fl.valid <= v3;
  end

  // stage 5: numerator magnitudes, coarse normalisation of |cross|^2
  vawj_pkg::side_t    sd5;
  vawj_pkg::side_t    sd5_w;
  logic [63:0]        c2_5;
  logic [2:0]         shi5;
  logic [63:0]        n5_w;
  logic [2:0]         shi_w;
  logic signed [49:0] nneg_w [6];

  always_comb begin
    n5_w  = c2_4;
    shi_w = '0;
    if (n5_w[63:32] == '0) begin n5_w = n5_w << 32; shi_w[2] = 1'b1; end
    if (n5_w[63:48] == '0) begin n5_w = n5_w << 16; shi_w[1] = 1'b1; end
    if (n5_w[63:56] == '0) begin n5_w = n5_w << 8;  shi_w[0] = 1'b1; end
    for (int j = 0; j < 6; j++) nneg_w[j] = -num4[j];
    sd5_w = sd4;
    for (int j = 0; j < 6; j++) begin
      sd5_w.neg[j] = num4[j][49];
      sd5_w.mag[j] = num4[j][49] ? nneg_w[j][48:0] : num4[j][48:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sd5 <= '0;
    else     sd5 <= sd5_w;
    c2_5 <= n5_w;
    shi5 <= shi_w;
  end

  // stage 6: fine normalisation, top two bits non-zero
  logic [63:0]     n6_w;
  logic [1:0]      slo_w;
  vawj_pkg::side_t side_w;

  always_comb begin
    n6_w  = c2_5;
    slo_w = '0;
    if (n6_w[63:60] == '0) begin n6_w = n6_w << 4; slo_w[1] = 1'b1; end
    if (n6_w[63:62] == '0) begin n6_w = n6_w << 2; slo_w[0] = 1'b1; end
    side_w   = sd5;
    side_w.s = {shi5, slo_w};
  end

  always_ff @(posedge clk) begin
    if (rst) side <= '0;
    else     side <= side_w;
    norm_c2 <= n6_w;
  end

endmodule

[hw/rtl/vawj_isqrt.sv]
module vawj_isqrt (
  input  logic             clk,
  input  logic             rst,
  input  vawj_pkg::side_t  side_in,
  input  logic [63:0]      v_in,
  output vawj_pkg::side_t  side_out,
  output logic [31:0]      root
);

  localparam int N = vawj_pkg::SQRT_STEPS;

  logic [63:0]     rem_q [N];
  logic [63:0]     rt_q  [N];
  vawj_pkg::side_t sd_q  [N];

  // one result bit per stage, restoring square root
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0]     rem_s, rt_s, trial;
    vawj_pkg::side_t sd_s;

    if (i == 0) begin : g_first
      assign rem_s = v_in;
      assign rt_s  = '0;
      assign sd_s  = side_in;
    end else begin : g_next
      assign rem_s = rem_q[i - 1];
      assign rt_s  = rt_q[i - 1];
      assign sd_s  = sd_q[i - 1];
    end

    assign trial = rt_s + BIT;

    always_ff @(posedge clk) begin
      if (rem_s >= trial) begin
        rem_q[i] <= rem_s - trial;
        rt_q[i]  <= (rt_s >> 1) + BIT;
      end else begin
        rem_q[i] <= rem_s;
        rt_q[i]  <= rt_s >> 1;
      end
      if (rst) sd_q[i] <= '0;
      else     sd_q[i] <= sd_s;
    end
  end

  assign side_out = sd_q[N - 1];
  assign root     = rt_q[N - 1][31:0];

endmodule

[hw/rtl/vawj_cordic.sv]
module vawj_cordic (
  input  logic        clk,
  input  logic [29:0] ax,
  input  logic [29:0] ay,
  input  logic        negdot,
  output logic [17:0] angle
);

  localparam int N = vawj_pkg::CORDIC_STEPS;

  logic signed [33:0] x_q [N];
  logic signed [33:0] y_q [N];
  logic signed [32:0] z_q [N];
  logic               n_q [N];

  // vectoring micro-rotations, floor shifts
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [32:0] ATAN = {3'b000, vawj_pkg::atan_q30(5'(i))};
    logic signed [33:0] x_s, y_s, dx, dy;
    logic signed [32:0] z_s;
    logic               n_s;

    if (i == 0) begin : g_first
      assign x_s = {4'b0000, ax};
      assign y_s = {4'b0000, ay};
      assign z_s = '0;
      assign n_s = negdot;
    end else begin : g_next
      assign x_s = x_q[i - 1];
      assign y_s = y_q[i - 1];
      assign z_s = z_q[i - 1];
      assign n_s = n_q[i - 1];
    end

    assign dx = y_s >>> i;
    assign dy = x_s >>> i;

    always_ff @(posedge clk) begin
      if (!y_s[33]) begin
        x_q[i] <= x_s + dx;
        y_q[i] <= y_s - dy;
        z_q[i] <= z_s + ATAN;
      end else begin
        x_q[i] <= x_s - dx;
        y_q[i] <= y_s + dy;
        z_q[i] <= z_s - ATAN;
      end
      n_q[i] <= n_s;
    end
  end

  // clamp, reflect for negative dot, round to Q16
  logic [33:0] zc_w, zf_w, q_w;

  always_comb begin
    if (z_q[N - 1][32])
      zc_w = '0;
    else if ({1'b0, z_q[N - 1]} > vawj_pkg::HALF_PI_Q30)
      zc_w = vawj_pkg::HALF_PI_Q30;
    else
      zc_w = {1'b0, z_q[N - 1]};
    zf_w = n_q[N - 1] ? (vawj_pkg::PI_Q30 - zc_w) : zc_w;
    q_w  = (zf_w + 34'd8192) >> 14;
  end

  always_ff @(posedge clk) begin
    if (q_w > 34'(vawj_pkg::PI_Q16)) angle <= vawj_pkg::PI_Q16;
    else                             angle <= q_w[17:0];
  end

endmodule

[hw/rtl/vawj_div.sv]
module vawj_div (
  input  logic               clk,
  input  logic [63:0]        den,
  input  logic [63:0]        rem0,
  input  logic [31:0]        low,
  input  logic               neg,
  output logic signed [31:0] grad
);

  localparam int N = vawj_pkg::DIV_STEPS;

  logic [63:0] rem_q [N];
  logic [63:0] den_q [N];
  logic [31:0] low_q [N];
  logic [31:0] quo_q [N];
  logic        neg_q [N];

  // one quotient bit per stage, restoring division
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [63:0] rem_s, den_s;
    logic [31:0] low_s, quo_s;
    logic        neg_s;
    logic [64:0] t_w, d_w;

    if (i == 0) begin : g_first
      assign rem_s = rem0;
      assign den_s = den;
      assign low_s = low;
      assign quo_s = '0;
      assign neg_s = neg;
    end else begin : g_next
      assign rem_s = rem_q[i - 1];
      assign den_s = den_q[i - 1];
      assign low_s = low_q[i - 1];
      assign quo_s = quo_q[i - 1];
      assign neg_s = neg_q[i - 1];
    end

    assign t_w = {rem_s, low_s[31]};
    assign d_w = t_w - {1'b0, den_s};

    always_ff @(posedge clk) begin
      if (t_w >= {1'b0, den_s}) begin
        rem_q[i] <= d_w[63:0];
        quo_q[i] <= {quo_s[30:0], 1'b1};
      end else begin
        rem_q[i] <= t_w[63:0];
        quo_q[i] <= {quo_s[30:0], 1'b0};
      end
      den_q[i] <= den_s;
      low_q[i] <= {low_s[30:0], 1'b0};
      neg_q[i] <= neg_s;
    end
  end

  // half away from zero, then saturate and apply sign
  logic [32:0] rnd_w;
  logic [31:0] mag_w, lim_w;

  always_comb begin
    rnd_w = ({1'b0, quo_q[N - 1]} + 33'd1) >> 1;
    lim_w = neg_q[N - 1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag_w = (rnd_w > {1'b0, lim_w}) ? lim_w : rnd_w[31:0];
  end

  always_ff @(posedge clk) begin
    grad <= neg_q[N - 1] ? -$signed(mag_w) : $signed(mag_w);
  end

endmodule

[hw/rtl/vector_angle_with_jacobian.sv]
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// input     | start, busy        | first_x/y/z, second_x/y/z (s16)
// result    | done (1-cycle)     | angle (u Q2.16), first/second_grad_x/y/z
//           |                    | (s Q1.30), degenerate
// config    | cfg_we             | cfg_index, cfg_data
//
// One item per cycle; results leave in the order of their transfers.
// Path: front, the 32-stage square root of |cross|^2, setup, then the
// 32-stage gradient dividers (the 30-stage CORDIC runs beside them).
// busy is high only during reset; rst clears every valid bit at once.
// Results are not held: the receiver takes done for its single cycle.
module vector_angle_with_jacobian (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] first_z,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic signed [15:0] second_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data,
  output logic               done,
  output logic [17:0]        angle,
  output logic signed [31:0] first_grad_x,
  output logic signed [31:0] first_grad_y,
  output logic signed [31:0] first_grad_z,
  output logic signed [31:0] second_grad_x,
  output logic signed [31:0] second_grad_y,
  output logic signed [31:0] second_grad_z,
  output logic               degenerate
);

  localparam int NL    = vawj_pkg::NUM_LANES;
  localparam int DLAT  = vawj_pkg::DIV_LAT;
  localparam int ALIGN = vawj_pkg::DIV_LAT - vawj_pkg::CORDIC_LAT;

  logic enable_first_jacobian, enable_second_jacobian;

  assign busy = rst;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_first_jacobian  <= 1'b1;
      enable_second_jacobian <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vawj_pkg::CFG_EN_FIRST:  enable_first_jacobian  <= cfg_data;
        vawj_pkg::CFG_EN_SECOND: enable_second_jacobian <= cfg_data;
        default: ;
      endcase
    end
  end

  // products, sums and normalisation
  vawj_pkg::side_t front_side, sq_side;
  logic [63:0]     norm_c2;
  logic [31:0]     root;

  vawj_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .first_x  (first_x),
    .first_y  (first_y),
    .first_z  (first_z),
    .second_x (second_x),
    .second_y (second_y),
    .second_z (second_z),
    .side     (front_side),
    .norm_c2  (norm_c2)
  );

  vawj_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .side_in  (front_side),
    .v_in     (norm_c2),
    .side_out (sq_side),
    .root     (root)
  );

  // setup 1: denominators, CORDIC prescale amount
  vawj_pkg::side_t sd1;
  logic [31:0]     root1;
  logic [63:0]     den_l1, den_r1, ax64_1;
  logic [5:0]      k1;
  logic [5:0]      top_w, k_w;

  always_comb begin
    top_w = sq_side.adot_nz ? (6'(sq_side.adot_msb) + 6'(sq_side.s)) : 6'd0;
    k_w   = (top_w > 6'd31) ? (top_w - 6'd29) : 6'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) sd1 <= '0;
    else     sd1 <= sq_side;
    root1  <= root;
    den_l1 <= sq_side.ll * root;
    den_r1 <= sq_side.rr * root;
    ax64_1 <= {32'b0, sq_side.adot} << sq_side.s;
    k1     <= k_w;
  end

  // setup 2: prescale CORDIC inputs, align dividends
  vawj_pkg::flags_t fl2;
  logic [29:0]      ax2, ay2;
  logic [63:0]      den2  [NL];
  logic [63:0]      rem2  [NL];
  logic [31:0]      low2  [NL];
  logic             neg2  [NL];
  logic [111:0]     num_w [NL];
  logic [63:0]      axs_w, ays_w;

  always_comb begin
    axs_w = ax64_1 >> k1;
    ays_w = {32'b0, root1} >> k1;
    for (int j = 0; j < NL; j++)
      num_w[j] = {63'b0, sd1.mag[j]} << (6'd31 + 6'(sd1.s));
  end

  always_ff @(posedge clk) begin
    if (rst) fl2 <= '0;
    else     fl2 <= sd1.fl;
    ax2 <= axs_w[29:0];
    ay2 <= ays_w[29:0];
    for (int j = 0; j < NL; j++) begin
      den2[j] <= (j < NL / 2) ? den_l1 : den_r1;
      rem2[j] <= num_w[j][95:32];
      low2[j] <= num_w[j][31:0];
      neg2[j] <= sd1.neg[j];
    end
  end

  // angle and gradient units
  logic [17:0]        angle_c;
  logic signed [31:0] grad_w [NL];

  vawj_cordic u_cordic (
    .clk    (clk),
    .ax     (ax2),
    .ay     (ay2),
    .negdot (fl2.negdot),
    .angle  (angle_c)
  );

  for (genvar j = 0; j < NL; j++) begin : g_lane
    vawj_div u_div (
      .clk  (clk),
      .den  (den2[j]),
      .rem0 (rem2[j]),
      .low  (low2[j]),
      .neg  (neg2[j]),
      .grad (grad_w[j])
    );
  end

  // flags follow the dividers; angle waits for them
  vawj_pkg::flags_t fl_q [DLAT];
  logic [17:0]      ang_q [ALIGN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DLAT; d++) fl_q[d] <= '0;
    end else begin
      fl_q[0] <= fl2;
      for (int d = 1; d < DLAT; d++) fl_q[d] <= fl_q[d - 1];
    end
    ang_q[0] <= angle_c;
    for (int d = 1; d < ALIGN; d++) ang_q[d] <= ang_q[d - 1];
  end

  // result register
  vawj_pkg::flags_t fo;
  logic             g1_on, g2_on;

  assign fo    = fl_q[DLAT - 1];
  assign g1_on = enable_first_jacobian && !fo.degen;
  assign g2_on = enable_second_jacobian && !fo.degen;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= fo.valid;
    degenerate <= fo.degen;
    if (fo.degen) angle <= fo.negdot ? vawj_pkg::PI_Q16 : 18'd0;
    else          angle <= ang_q[ALIGN - 1];
    first_grad_x  <= g1_on ? grad_w[0] : 32'sd0;
    first_grad_y  <= g1_on ? grad_w[1] : 32'sd0;
    first_grad_z  <= g1_on ? grad_w[2] : 32'sd0;
    second_grad_x <= g2_on ? grad_w[3] : 32'sd0;
    second_grad_y <= g2_on ? grad_w[4] : 32'sd0;
    second_grad_z <= g2_on ? grad_w[5] : 32'sd0;
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, vawj_pkg::TOTAL_LAT))
    else $error("result without a matching input transfer");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> angle <= vawj_pkg::PI_Q16)
    else $error("angle above pi");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (first_grad_x == 0 && first_grad_y == 0 &&
      first_grad_z == 0 && second_grad_x == 0 && second_grad_y == 0 &&
      second_grad_z == 0))
    else $error("degenerate result with non-zero gradient");

  a_first_off: assert property (@(posedge clk) disable iff (rst)
    (done && !enable_first_jacobian) |->
      (first_grad_x == 0 && first_grad_y == 0 && first_grad_z == 0))
    else $error("first gradient given while disabled");

  a_second_off: assert property (@(posedge clk) disable iff (rst)
    (done && !enable_second_jacobian) |->
      (second_grad_x == 0 && second_grad_y == 0 && second_grad_z == 0))
    else $error("second gradient given while disabled");

endmodule
